FILE: hw/rtl/grq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grq_pkg: shared types and constants of the generation-tagged ring queue
// Holds the ring geometry, the action and status codes, the item structs of
// both channels and the command and status groups between the controller and
// the datapath.
// ----------------------------------------------------------------------------
package grq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int POS_W       = $clog2(QUEUE_DEPTH);
   localparam int GEN_W       = 32;
   localparam int OUT_DATA_W  = 32;
   localparam int CNT_W       = $clog2(2 * QUEUE_DEPTH);

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_FREE = 2'd2;
   localparam logic [1:0] ACT_PEEK = 2'd3;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_MISS  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [POS_W-1:0]      hint_pos;
      logic [GEN_W-1:0]      hint_gen;
      logic [OUT_DATA_W-1:0] push_data;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [OUT_DATA_W-1:0] item_data;
      logic [POS_W-1:0]      next_pos;
      logic [GEN_W-1:0]      next_gen;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/grq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grq_ctrl: request sequencer of the generation-tagged ring queue
// Accepts one request at a time, steps the slot scan until the datapath
// reports a decision, and commits the result into the output register once
// that register is free.
// ----------------------------------------------------------------------------
module grq_ctrl
   import grq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type dp_status
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      req_stall  = (state_ff != S_IDLE);
      cmd.load   = req_valid && (state_ff == S_IDLE);
      cmd.commit = (state_ff == S_SCAN) && dp_status.done && out_free;
      cmd.step   = (state_ff == S_SCAN) && !dp_status.done;

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.load) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmd.commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/grq_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grq_dpath: slot storage and scan datapath of the generation-tagged ring queue
// Keeps the slot generations, full flags and data words, walks the scan
// position and working generation one slot per step, and builds the result.
// ----------------------------------------------------------------------------
module grq_dpath
   import grq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req_item,
   input  wire dp_cmd_type cmd,
   output dp_status_type   dp_status,
   output rsp_type         rsp_item
);

   logic [GEN_W-1:0]      slot_gen_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] slot_full_ff;
   logic [DATA_WIDTH-1:0] slot_data_ff [QUEUE_DEPTH];

   logic [1:0]            act_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [GEN_W-1:0]      gen_ff;
   logic [DATA_WIDTH-1:0] wdata_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  range_ff;

   logic [1:0]            rsp_status_ff;
   logic [OUT_DATA_W-1:0] rsp_data_ff;
   logic [POS_W-1:0]      rsp_pos_ff;
   logic [GEN_W-1:0]      rsp_gen_ff;

   logic [GEN_W-1:0] cur_gen;
   logic [GEN_W-1:0] gen_plus;
   logic             cur_full;
   logic             fill_side;
   logic             modify;
   logic             match_cur;
   logic             match_next;
   logic             hit;
   logic             brk;
   logic             last;
   logic             wrap;
   logic [POS_W-1:0] adv_pos;
   logic [GEN_W-1:0] adv_gen;
   logic             do_effect;
   logic             read_data;

   always_comb begin
      cur_gen    = slot_gen_ff[pos_ff];
      cur_full   = slot_full_ff[pos_ff];
      gen_plus   = gen_ff + GEN_W'(1);
      fill_side  = (act_ff == ACT_PUSH) || (act_ff == ACT_FREE);
      modify     = (act_ff == ACT_PUSH) || (act_ff == ACT_POP);
      match_cur  = (cur_gen == gen_ff);
      match_next = (cur_gen == gen_plus);
      if (fill_side) begin
         hit = match_cur && !cur_full;
         brk = match_cur && cur_full;
      end else begin
         hit = match_next && cur_full;
         brk = match_cur && !cur_full;
      end
      if (modify) begin
         last = (cnt_ff == CNT_W'(QUEUE_DEPTH - 1));
      end else begin
         last = (cnt_ff == CNT_W'(2 * QUEUE_DEPTH - 1));
      end
      wrap           = (pos_ff == POS_W'(QUEUE_DEPTH - 1));
      adv_pos        = wrap ? '0 : pos_ff + POS_W'(1);
      adv_gen        = wrap ? gen_plus : gen_ff;
      dp_status.done = range_ff || hit || brk || last;
      do_effect      = cmd.commit && !range_ff && hit;
      read_data      = do_effect && ((act_ff == ACT_POP) || (act_ff == ACT_PEEK));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_item.action;
         pos_ff   <= req_item.hint_pos;
         gen_ff   <= req_item.hint_gen;
         wdata_ff <= req_item.push_data[DATA_WIDTH-1:0];
         cnt_ff   <= '0;
         range_ff <= ({1'b0, req_item.hint_pos} >= (POS_W + 1)'(QUEUE_DEPTH));
      end else if (cmd.step) begin
         pos_ff <= adv_pos;
         gen_ff <= adv_gen;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUEUE_DEPTH; k++) begin
            slot_gen_ff[k] <= '0;
         end
         slot_full_ff <= '0;
      end else if (do_effect) begin
         if (act_ff == ACT_PUSH) begin
            slot_gen_ff[pos_ff]  <= gen_plus;
            slot_full_ff[pos_ff] <= 1'b1;
         end else if (act_ff == ACT_POP) begin
            slot_full_ff[pos_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_effect && (act_ff == ACT_PUSH)) begin
         slot_data_ff[pos_ff] <= wdata_ff;
      end
      if (cmd.commit) begin
         if (read_data) begin
            rsp_data_ff <= OUT_DATA_W'(slot_data_ff[pos_ff]);
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (range_ff) begin
            rsp_status_ff <= STAT_RANGE;
            rsp_pos_ff    <= pos_ff;
            rsp_gen_ff    <= gen_ff;
         end else if (hit) begin
            rsp_status_ff <= STAT_OK;
            rsp_pos_ff    <= adv_pos;
            rsp_gen_ff    <= adv_gen;
         end else if (brk) begin
            rsp_status_ff <= STAT_MISS;
            rsp_pos_ff    <= pos_ff;
            rsp_gen_ff    <= gen_ff;
         end else begin
            rsp_status_ff <= STAT_MISS;
            rsp_pos_ff    <= adv_pos;
            rsp_gen_ff    <= adv_gen;
         end
      end
   end

   always_comb begin
      rsp_item.status    = rsp_status_ff;
      rsp_item.item_data = rsp_data_ff;
      rsp_item.next_pos  = rsp_pos_ff;
      rsp_item.next_gen  = rsp_gen_ff;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/generation_tagged_ring_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// generation_tagged_ring_queue: bounded ring queue with slot generations
// Push, pop, find-free and peek requests scan the ring from a client hint.
// ----------------------------------------------------------------------------
// A request is taken and then scans one slot per cycle from its hint
// position until it hits, stops on a full or empty queue, or runs out of
// slots, which is after at most 16 slots for push and pop or 32 slots for
// find-free and peek. The single slot read port of the scan sets this pace.
// Requests are handled one at a time, but a new request is taken while the
// previous result still waits in the output register; the scan then holds
// its final step until that register is free.
module generation_tagged_ring_queue
   import grq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   grq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .dp_status (dp_status)
   );

   grq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_item  (rsp_item)
   );

   a_commit_needs_free_output: assert property (
      @(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid && rsp_stall)
   ) else $error("A result was committed over one still waiting.");

   a_busy_after_accept: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("The block did not start a scan after taking a request.");

   a_result_from_scan: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("A result appeared without a scan in progress.");

   a_commands_exclusive: assert property (
      @(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.commit || cmd.step)) && !(cmd.commit && cmd.step)
   ) else $error("The controller issued conflicting datapath commands.");

endmodule
`default_nettype wire
